// ===== rtl/core/rsch_pkg.sv =====
// Package for the ray / sphere closest-hit block: beat types, register
// indexes, reset values and internal widths. No dependencies.
package rsch_pkg;

  localparam int MAX_SPHERES = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 15;
  localparam int DIFF_W      = 17;  // o - c, Q9.8
  localparam int PROD_W      = 33;  // d * (o - c), scale 2^-22
  localparam int B22_W       = 35;  // sum of three products
  localparam int B16_W       = 29;  // rounded b, scale 2^-16
  localparam int BSQ_W       = 58;
  localparam int SQ_W        = 32;  // (o - c)^2 per axis
  localparam int RR_W        = 30;  // r^2
  localparam int LR_W        = 35;  // |o - c|^2 - r^2, scale 2^-16
  localparam int DISC_W      = 60;
  localparam int REM_W       = 56;  // non-negative disc
  localparam int ROOT_W      = 28;  // floor sqrt of disc
  localparam int TRIAL_W     = 57;
  localparam int T_W         = 30;  // roots, signed
  localparam int DIST_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAY_ORIGIN    = 3'd0,
    REG_SPHERE_RADIUS = 3'd1,
    REG_CENTRE_ZERO   = 3'd2,
    REG_CENTRE_ONE    = 3'd3,
    REG_CENTRE_TWO    = 3'd4,
    REG_CENTRE_THREE  = 3'd5
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] RST_ORIGIN  = 48'h0000_0000_0500;
  localparam logic [RADIUS_W-1:0]   RST_RADIUS  = 15'd256;
  localparam logic [CFG_DATA_W-1:0] RST_CENTRE0 = 48'hFE00_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_CENTRE1 = 48'h0200_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_CENTRE2 = 48'hFE00_0000_FE00;
  localparam logic [CFG_DATA_W-1:0] RST_CENTRE3 = 48'h0180_0100_FF00;

  typedef struct packed {
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_dir_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        sphere_index;
    logic [DIST_W-1:0] hit_distance;
  } hit_res_t;

endpackage

// ===== rtl/core/ray_sphere_closest_hit_top.sv =====
// Ray / sphere closest-hit pipeline, top level.
// Depends on rsch_pkg (beat types, register indexes, widths).
//
//   channel   dir   handshake                 payload
//   in        in    in_valid_i / in_ready_o   ray_dir_t  (dir_x, dir_y, dir_z)
//   out       out   out_valid_o / out_ready_i hit_res_t  (hit, sphere_index, hit_distance)
//   cfg       in    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled. The depth
// is set by the square root: one result bit per stage, 28 stages, one lane
// per sphere. Reset clears valid bits and loads the register defaults. A
// stall at the output freezes the whole pipeline in place; cfg_ready_o is
// always high.
module ray_sphere_closest_hit_top
  import rsch_pkg::*;
#(
  parameter int SPHERE_COUNT = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ray_dir_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hit_res_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SQ_STEPS = ROOT_W;
  // dir, products, b, b^2, disc, sqrt steps, roots, select, output
  localparam int NSTG     = 5 + SQ_STEPS + 3;

  function automatic logic signed [COORD_W-1:0] coord(input logic [CFG_DATA_W-1:0] p,
                                                      input int unsigned k);
    case (k)
      0:       return p[47:32];
      1:       return p[31:16];
      default: return p[15:0];
    endcase
  endfunction

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] origin_q;
  logic [RADIUS_W-1:0]   radius_q;
  logic [CFG_DATA_W-1:0] centre_q [MAX_SPHERES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q    <= RST_ORIGIN;
      radius_q    <= RST_RADIUS;
      centre_q[0] <= RST_CENTRE0;
      centre_q[1] <= RST_CENTRE1;
      centre_q[2] <= RST_CENTRE2;
      centre_q[3] <= RST_CENTRE3;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RAY_ORIGIN:    origin_q    <= cfg_data_i;
        REG_SPHERE_RADIUS: radius_q    <= cfg_data_i[RADIUS_W-1:0];
        REG_CENTRE_ZERO:   centre_q[0] <= cfg_data_i;
        REG_CENTRE_ONE:    centre_q[1] <= cfg_data_i;
        REG_CENTRE_TWO:    centre_q[2] <= cfg_data_i;
        REG_CENTRE_THREE:  centre_q[3] <= cfg_data_i;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // r^2, free running; the user must move config only while the pipe is empty, the block does not enforce it
  logic [RR_W-1:0] rr_q;
  always_ff @(posedge clk_i) begin
    rr_q <= radius_q * radius_q;
  end

  // ---------------- pipeline control ----------------
  // Whole pipe advances together; stalls only when the output beat waits.
  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 0: direction capture
  ray_dir_t dir_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir_q <= in_data_i;
    end
  end

  // per-lane results at the roots stage
  logic             lhit_q [SPHERE_COUNT];
  logic [T_W-2:0]   tsel_q [SPHERE_COUNT];

  for (genvar g = 0; g < SPHERE_COUNT; g++) begin : g_lane
    logic signed [DIFF_W-1:0] diff_w [3];
    logic [SQ_W-1:0]          sq_q   [3];
    logic signed [LR_W-1:0]   lr_q;
    logic signed [PROD_W-1:0] prod_q [3];
    logic signed [B22_W-1:0]  b22_w;
    logic signed [B16_W-1:0]  b16_q;
    logic signed [B16_W-1:0]  b16b_q;
    logic signed [BSQ_W-1:0]  bsq_q;
    logic signed [DISC_W-1:0] disc_w;
    logic [REM_W-1:0]         rem_q  [SQ_STEPS+1];
    logic [ROOT_W-1:0]        root_q [SQ_STEPS+1];
    logic signed [B16_W-1:0]  bc_q   [SQ_STEPS+1];
    logic                     neg_q  [SQ_STEPS+1];
    logic signed [T_W-1:0]    ta_w;
    logic signed [T_W-1:0]    tb_w;

    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign diff_w[k] = DIFF_W'(coord(origin_q, k)) - DIFF_W'(coord(centre_q[g], k));
      always_ff @(posedge clk_i) begin
        sq_q[k] <= SQ_W'(diff_w[k] * diff_w[k]);
      end
    end

    // |o - c|^2 - r^2, free running
    always_ff @(posedge clk_i) begin
      lr_q <= $signed({3'b000, sq_q[0]}) + $signed({3'b000, sq_q[1]})
            + $signed({3'b000, sq_q[2]}) - $signed({5'b00000, rr_q});
    end

    // stage 1: d * (o - c) per axis
    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[0] <= PROD_W'(dir_q.dir_x) * PROD_W'(diff_w[0]);
        prod_q[1] <= PROD_W'(dir_q.dir_y) * PROD_W'(diff_w[1]);
        prod_q[2] <= PROD_W'(dir_q.dir_z) * PROD_W'(diff_w[2]);
      end
    end

    // stage 2: b rounded to 2^-16, ties up (floor of (b22 + 32) / 64)
    assign b22_w = B22_W'(prod_q[0]) + B22_W'(prod_q[1]) + B22_W'(prod_q[2])
                 + B22_W'(32);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        b16_q <= b22_w[B22_W-1:6];
      end
    end

    // stage 3: b^2
    always_ff @(posedge clk_i) begin
      if (adv) begin
        bsq_q  <= BSQ_W'(b16_q) * BSQ_W'(b16_q);
        b16b_q <= b16_q;
      end
    end

    // stage 4: disc = b^2 - (|o - c|^2 - r^2) at 2^-32
    assign disc_w = DISC_W'(bsq_q) - (DISC_W'(lr_q) <<< 16);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg_q[0]  <= disc_w[DISC_W-1];
        rem_q[0]  <= disc_w[REM_W-1:0];
        root_q[0] <= '0;
        bc_q[0]   <= b16b_q;
      end
    end

    // sqrt: one root bit per stage, msb first
    for (genvar s = 1; s <= SQ_STEPS; s++) begin : g_sqrt
      localparam int J = SQ_STEPS - s;
      logic [TRIAL_W-1:0] trial_w;
      logic               take_w;

      assign trial_w = (TRIAL_W'(root_q[s-1]) << (J + 1)) + (TRIAL_W'(1) << (2 * J));
      assign take_w  = {1'b0, rem_q[s-1]} >= trial_w;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          neg_q[s] <= neg_q[s-1];
          bc_q[s]  <= bc_q[s-1];
          if (take_w) begin
            rem_q[s]  <= rem_q[s-1] - trial_w[REM_W-1:0];
            root_q[s] <= root_q[s-1] | (ROOT_W'(1) << J);
          end else begin
            rem_q[s]  <= rem_q[s-1];
            root_q[s] <= root_q[s-1];
          end
        end
      end
    end

    // roots stage: nearer root in front of the origin, else the far one
    assign ta_w = $signed({2'b00, root_q[SQ_STEPS]}) - T_W'(bc_q[SQ_STEPS]);
    assign tb_w = -T_W'(bc_q[SQ_STEPS]) - $signed({2'b00, root_q[SQ_STEPS]});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        lhit_q[g] <= !neg_q[SQ_STEPS] && !ta_w[T_W-1];
        tsel_q[g] <= tb_w[T_W-1] ? ta_w[T_W-2:0] : tb_w[T_W-2:0];
      end
    end
  end

  // select stage: closest lane, lower index wins a tie
  logic           found_w;
  logic [1:0]     idx_w;
  logic [T_W-2:0] best_w;
  logic           found_q;
  logic [1:0]     idx_q;
  logic [T_W-2:0] best_q;

  always_comb begin
    found_w = 1'b0;
    idx_w   = '0;
    best_w  = '0;
    for (int i = 0; i < SPHERE_COUNT; i++) begin
      if (lhit_q[i] && (!found_w || tsel_q[i] < best_w)) begin
        found_w = 1'b1;
        idx_w   = 2'(i);
        best_w  = tsel_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      found_q <= found_w;
      idx_q   <= idx_w;
      best_q  <= best_w;
    end
  end

  // output stage: Q8.8 distance, saturated
  hit_res_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.hit          <= found_q;
      out_q.sphere_index <= idx_q;
      out_q.hit_distance <= (|best_q[T_W-2:24]) ? {DIST_W{1'b1}} : best_q[23:8];
    end
  end

  assign out_data_o = out_q;

endmodule
